// File: rtl/websocket_frame_deframer_defines.svh
// assertion macros for the websocket frame deframer
`ifndef WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH
`define WEBSOCKET_FRAME_DEFRAMER_DEFINES_SVH

// same-cycle implication, checked outside reset
`define WSFD_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define WSFD_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: rtl/wsfd_pkg.sv
// types and constants shared by the websocket frame deframer
package wsfd_pkg;

  // width kept for the payload length counter
  localparam int LEN_BITS = 32;

  // header codes
  localparam logic [3:0] OP_CONT = 4'h0;
  localparam logic [3:0] OP_TEXT = 4'h1;
  localparam logic [3:0] OP_BIN  = 4'h2;
  localparam logic [3:0] OP_PING = 4'h9;
  localparam logic [3:0] OP_PONG = 4'hA;

  localparam logic [6:0] LEN_SHORT_MAX = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;
  localparam logic [3:0] EXT16_BYTES   = 4'd2;
  localparam logic [3:0] EXT64_BYTES   = 4'd8;

  // frame classes
  typedef enum logic [3:0] {
    CLS_NONE         = 4'd0,
    CLS_TEXT         = 4'd1,
    CLS_PART_TEXT    = 4'd2,
    CLS_BINARY       = 4'd3,
    CLS_PART_BINARY  = 4'd4,
    CLS_PING         = 4'd5,
    CLS_PONG         = 4'd6,
    CLS_ERROR        = 4'd7,
    CLS_INCOMPLETE   = 4'd8
  } class_e;

  // parse phases
  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_HDR1    = 3'd1,
    PH_EXT     = 3'd2,
    PH_MASK    = 3'd3,
    PH_PAYLOAD = 3'd4,
    PH_DONE    = 3'd5
  } phase_e;

  // input word
  typedef struct packed {
    logic [7:0] data_byte;
    logic       buffer_end;
  } in_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       byte_valid;
    logic       frame_end;
    logic [3:0] frame_class;
  } out_t;

  // parser result toward the output register
  typedef struct packed {
    logic res_valid;
    out_t res;
  } step_t;

endpackage

// File: rtl/websocket_frame_deframer.sv
// websocket frame deframer top level: input register, parser, result register
//
// Input channel: one buffer byte per word (in_data_i), buffer_end set on the
// last byte of a received buffer. A word is taken when in_valid_i is high and
// in_stall_o is low.
// Output channel: zero or one result word per input byte. Payload bytes come
// out unmasked with byte_valid set; the last result of a frame has frame_end
// set and carries the frame class. Header, key and trailing bytes give no
// word unless they close the frame or the buffer.
// A taken byte waits in the input register and its result word is offered
// from the result register. Throughput: one byte per cycle unless stalled,
// set by the single parse step between the input and result registers.
// Stall: the result register holds while out_stall_i is high; bytes that
// give no result keep flowing, and in_stall_o rises only when a byte that
// gives a result waits behind a held result word.
// Reset: all frame state clears and the next byte is read as the first
// header byte; the same happens after every byte with buffer_end.
`include "websocket_frame_deframer_defines.svh"

module websocket_frame_deframer (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  output logic           in_stall_o,
  input  wsfd_pkg::in_t  in_data_i,
  output logic           out_valid_o,
  input  logic           out_stall_i,
  output wsfd_pkg::out_t out_data_o
);

  wsfd_pkg::in_t   in_q;
  logic            in_v_q;
  wsfd_pkg::out_t  out_q;
  logic            out_v_q;
  wsfd_pkg::step_t step_s;
  logic            out_free;
  logic            step_go;

  // a byte moves on when its result, if any, has room
  assign out_free   = !out_v_q || !out_stall_i;
  assign step_go    = in_v_q && (!step_s.res_valid || out_free);
  assign in_stall_o = in_v_q && !step_go;

  wsfd_parser u_parser (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_en_i (step_go),
    .item_i    (in_q),
    .step_o    (step_s)
  );

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_v_q <= 1'b0;
    end else if (in_valid_i && !in_stall_o) begin
      in_v_q <= 1'b1;
    end else if (step_go) begin
      in_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && !in_stall_o) begin
      in_q <= in_data_i;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (step_go && step_s.res_valid) begin
      out_v_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_v_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step_go && step_s.res_valid) begin
      out_q <= step_s.res;
    end
  end

  assign out_valid_o = out_v_q;
  assign out_data_o  = out_q;

  // checks
  `WSFD_ASSERT_IMPL(a_mid_frame_no_class,
    out_valid_o && !out_data_o.frame_end,
    out_data_o.frame_class == wsfd_pkg::CLS_NONE,
    "non-final result carries a frame class")
  `WSFD_ASSERT_IMPL(a_idle_byte_zero,
    out_valid_o && !out_data_o.byte_valid,
    out_data_o.out_byte == 8'd0,
    "result without payload byte has nonzero data")
  `WSFD_ASSERT_IMPL(a_stall_needs_item,
    in_stall_o,
    in_v_q && out_v_q && out_stall_i,
    "input stalled without a held byte and a held result")

endmodule

// File: rtl/wsfd_parser.sv
// frame header parser, mask key store and payload unmasking
module wsfd_parser (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            step_en_i,
  input  wsfd_pkg::in_t   item_i,
  output wsfd_pkg::step_t step_o
);

  wsfd_pkg::phase_e                phase_q, phase_d;
  logic [3:0]                      opcode_q, opcode_d;
  logic                            fin_q, fin_d;
  logic                            masked_q, masked_d;
  logic [wsfd_pkg::LEN_BITS-1:0]   len_q, len_d;
  logic [3:0]                      ext_q, ext_d;
  logic [3:0][7:0]                 key_q, key_d;
  logic [1:0]                      idx_q, idx_d;
  logic                            ovf_q, ovf_d;

  logic       final_s;
  logic [7:0] b;
  logic [6:0] lf;
  logic       ovf_s;

  // class of a finished frame from the held header
  function automatic wsfd_pkg::class_e class_of(logic [3:0] op, logic fin);
    wsfd_pkg::class_e c;
    case (op)
      wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT: c = fin ? wsfd_pkg::CLS_TEXT
                                                    : wsfd_pkg::CLS_PART_TEXT;
      wsfd_pkg::OP_BIN:  c = fin ? wsfd_pkg::CLS_BINARY : wsfd_pkg::CLS_PART_BINARY;
      wsfd_pkg::OP_PING: c = wsfd_pkg::CLS_PING;
      wsfd_pkg::OP_PONG: c = wsfd_pkg::CLS_PONG;
      default:           c = wsfd_pkg::CLS_ERROR;
    endcase
    return c;
  endfunction

  // next state and result for one byte
  always_comb begin
    phase_d  = phase_q;
    opcode_d = opcode_q;
    fin_d    = fin_q;
    masked_d = masked_q;
    len_d    = len_q;
    ext_d    = ext_q;
    key_d    = key_q;
    idx_d    = idx_q;
    ovf_d    = ovf_q;
    final_s  = 1'b0;
    b        = item_i.data_byte;
    lf       = b[6:0];
    ovf_s    = ovf_q;
    step_o   = '0;

    unique case (phase_q)
      wsfd_pkg::PH_IDLE: begin
        opcode_d = b[3:0];
        fin_d    = b[7];
        phase_d  = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        masked_d = b[7];
        len_d    = '0;
        if (lf <= wsfd_pkg::LEN_SHORT_MAX) begin
          len_d = {{(wsfd_pkg::LEN_BITS-7){1'b0}}, lf};
          if (b[7]) begin
            phase_d = wsfd_pkg::PH_MASK;
            idx_d   = '0;
          end else if (lf == '0) begin
            phase_d = wsfd_pkg::PH_DONE;
            final_s = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end else begin
          ext_d   = (lf == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                : wsfd_pkg::EXT64_BYTES;
          phase_d = wsfd_pkg::PH_EXT;
        end
      end
      wsfd_pkg::PH_EXT: begin
        // big-endian length, flag bits shifted past the counter
        ovf_s = ovf_q | (len_q[wsfd_pkg::LEN_BITS-1 -: 8] != '0);
        ovf_d = ovf_s;
        len_d = {len_q[wsfd_pkg::LEN_BITS-9:0], b};
        ext_d = ext_q - 4'd1;
        if (ext_q == 4'd1) begin
          if (ovf_s) begin
            phase_d                 = wsfd_pkg::PH_DONE;
            step_o.res_valid        = 1'b1;
            step_o.res.frame_end    = 1'b1;
            step_o.res.frame_class  = wsfd_pkg::CLS_ERROR;
          end else if (masked_q) begin
            phase_d = wsfd_pkg::PH_MASK;
            idx_d   = '0;
          end else if (len_d == '0) begin
            phase_d = wsfd_pkg::PH_DONE;
            final_s = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_MASK: begin
        key_d[idx_q] = b;
        idx_d        = idx_q + 2'd1;
        if (idx_q == 2'd3) begin
          if (len_q == '0) begin
            phase_d = wsfd_pkg::PH_DONE;
            final_s = 1'b1;
          end else begin
            phase_d = wsfd_pkg::PH_PAYLOAD;
          end
        end
      end
      wsfd_pkg::PH_PAYLOAD: begin
        step_o.res.out_byte   = masked_q ? (b ^ key_q[idx_q]) : b;
        step_o.res.byte_valid = 1'b1;
        step_o.res_valid      = 1'b1;
        idx_d                 = idx_q + 2'd1;
        len_d                 = len_q - {{(wsfd_pkg::LEN_BITS-1){1'b0}}, 1'b1};
        if (len_q == {{(wsfd_pkg::LEN_BITS-1){1'b0}}, 1'b1}) begin
          phase_d = wsfd_pkg::PH_DONE;
          final_s = 1'b1;
        end
      end
      default: begin
      end
    endcase

    // frame complete on this byte
    if (final_s) begin
      step_o.res_valid       = 1'b1;
      step_o.res.frame_end   = 1'b1;
      step_o.res.frame_class = class_of(opcode_q, fin_q);
    end

    // buffer end: report a cut frame, then start over
    if (item_i.buffer_end) begin
      if (phase_d != wsfd_pkg::PH_DONE) begin
        step_o.res_valid       = 1'b1;
        step_o.res.frame_end   = 1'b1;
        step_o.res.frame_class = wsfd_pkg::CLS_INCOMPLETE;
      end
      phase_d  = wsfd_pkg::PH_IDLE;
      opcode_d = '0;
      fin_d    = 1'b0;
      masked_d = 1'b0;
      len_d    = '0;
      ext_d    = '0;
      key_d    = '0;
      idx_d    = '0;
      ovf_d    = 1'b0;
    end
  end

  // frame state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= wsfd_pkg::PH_IDLE;
      opcode_q <= '0;
      fin_q    <= 1'b0;
      masked_q <= 1'b0;
      len_q    <= '0;
      ext_q    <= '0;
      key_q    <= '0;
      idx_q    <= '0;
      ovf_q    <= 1'b0;
    end else if (step_en_i) begin
      phase_q  <= phase_d;
      opcode_q <= opcode_d;
      fin_q    <= fin_d;
      masked_q <= masked_d;
      len_q    <= len_d;
      ext_q    <= ext_d;
      key_q    <= key_d;
      idx_q    <= idx_d;
      ovf_q    <= ovf_d;
    end
  end

endmodule

// File: tb/websocket_frame_deframer_checker.sv
// result checker for the websocket frame deframer: parses each byte and compares result words
`timescale 1ns / 100ps

module websocket_frame_deframer_checker (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           in_valid_i,
  input  logic           in_stall_i,
  input  wsfd_pkg::in_t  in_data_i,
  input  logic           out_valid_i,
  input  logic           out_stall_i,
  input  wsfd_pkg::out_t out_data_i,
  output int unsigned    mismatches_o,
  output int unsigned    pending_o,
  output int unsigned    words_in_o,
  output int unsigned    results_o,
  output int unsigned    frames_o,
  output logic [8:0]     classes_o
);

  // parser state, mirrors the frame being received
  wsfd_pkg::phase_e              phase;
  logic [3:0]                    op_q;
  logic                          fin_q;
  logic                          masked_q;
  logic [wsfd_pkg::LEN_BITS-1:0] len_left;
  logic [3:0]                    ext_left;
  logic [31:0]                   key_q;
  logic [1:0]                    key_idx;
  logic                          overflow;

  // result words still due from the block, oldest first
  wsfd_pkg::out_t due_words[$];

  int unsigned mismatches;
  int unsigned words_in;
  int unsigned results;
  int unsigned frames;
  logic [8:0]  classes;

  function automatic void clear_frame();
    phase    = wsfd_pkg::PH_IDLE;
    op_q     = '0;
    fin_q    = 1'b0;
    masked_q = 1'b0;
    len_left = '0;
    ext_left = '0;
    key_q    = '0;
    key_idx  = '0;
    overflow = 1'b0;
  endfunction

  function automatic wsfd_pkg::class_e frame_kind();
    case (op_q)
      wsfd_pkg::OP_CONT, wsfd_pkg::OP_TEXT:
        return fin_q ? wsfd_pkg::CLS_TEXT : wsfd_pkg::CLS_PART_TEXT;
      wsfd_pkg::OP_BIN:
        return fin_q ? wsfd_pkg::CLS_BINARY : wsfd_pkg::CLS_PART_BINARY;
      wsfd_pkg::OP_PING: return wsfd_pkg::CLS_PING;
      wsfd_pkg::OP_PONG: return wsfd_pkg::CLS_PONG;
      default:           return wsfd_pkg::CLS_ERROR;
    endcase
  endfunction

  // header and key done: empty payload closes the frame right here
  function automatic logic payload_start();
    if (len_left == '0) begin
      phase = wsfd_pkg::PH_DONE;
      return 1'b1;
    end
    phase = wsfd_pkg::PH_PAYLOAD;
    return 1'b0;
  endfunction

  // length known: collect the key when the frame is masked
  function automatic logic length_known();
    if (masked_q) begin
      phase   = wsfd_pkg::PH_MASK;
      key_idx = '0;
      return 1'b0;
    end
    return payload_start();
  endfunction

  // one byte through the parser, queues the result word it gives
  task automatic parse_byte(input wsfd_pkg::in_t w);
    logic [7:0]     b;
    wsfd_pkg::out_t r;
    logic           has_res;
    logic           closes;
    b       = w.data_byte;
    r       = '0;
    has_res = 1'b0;
    closes  = 1'b0;
    case (phase)
      wsfd_pkg::PH_IDLE: begin
        op_q  = b[3:0];
        fin_q = b[7];
        phase = wsfd_pkg::PH_HDR1;
      end
      wsfd_pkg::PH_HDR1: begin
        masked_q = b[7];
        len_left = '0;
        if (b[6:0] <= wsfd_pkg::LEN_SHORT_MAX) begin
          len_left = {{(wsfd_pkg::LEN_BITS-7){1'b0}}, b[6:0]};
          closes   = length_known();
        end else begin
          ext_left = (b[6:0] == wsfd_pkg::LEN_EXT16) ? wsfd_pkg::EXT16_BYTES
                                                     : wsfd_pkg::EXT64_BYTES;
          phase    = wsfd_pkg::PH_EXT;
        end
      end
      wsfd_pkg::PH_EXT: begin
        // big-endian length, anything past LEN_BITS is an error
        if ((len_left >> (wsfd_pkg::LEN_BITS - 8)) != '0) overflow = 1'b1;
        len_left = {len_left[wsfd_pkg::LEN_BITS-9:0], b};
        ext_left = ext_left - 4'd1;
        if (ext_left == '0) begin
          if (overflow) begin
            phase         = wsfd_pkg::PH_DONE;
            has_res       = 1'b1;
            r.frame_end   = 1'b1;
            r.frame_class = wsfd_pkg::CLS_ERROR;
          end else begin
            closes = length_known();
          end
        end
      end
      wsfd_pkg::PH_MASK: begin
        key_q   = key_q | (32'(b) << (8 * key_idx));
        key_idx = key_idx + 2'd1;
        if (key_idx == '0) closes = payload_start();
      end
      wsfd_pkg::PH_PAYLOAD: begin
        r.out_byte   = masked_q ? (b ^ key_q[8*key_idx +: 8]) : b;
        r.byte_valid = 1'b1;
        has_res      = 1'b1;
        key_idx      = key_idx + 2'd1;
        len_left     = len_left - {{(wsfd_pkg::LEN_BITS-1){1'b0}}, 1'b1};
        if (len_left == '0) begin
          phase  = wsfd_pkg::PH_DONE;
          closes = 1'b1;
        end
      end
      default: ;
    endcase

    if (closes) begin
      has_res       = 1'b1;
      r.frame_end   = 1'b1;
      r.frame_class = frame_kind();
    end

    // buffer end: incomplete unless the frame already closed, then start over
    if (w.buffer_end) begin
      if (phase != wsfd_pkg::PH_DONE) begin
        has_res       = 1'b1;
        r.frame_end   = 1'b1;
        r.frame_class = wsfd_pkg::CLS_INCOMPLETE;
      end
      clear_frame();
    end

    if (has_res) due_words.push_back(r);
  endtask

  // watch both channels: predict on input words, compare on result words
  always @(posedge clk_i or negedge rst_ni) begin : watch
    wsfd_pkg::out_t want;
    wsfd_pkg::out_t got;
    if (!rst_ni) begin
      clear_frame();
      due_words.delete();
      mismatches = 0;
      words_in   = 0;
      results    = 0;
      frames     = 0;
      classes    = '0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        words_in++;
        parse_byte(in_data_i);
      end
      if (out_valid_i && !out_stall_i) begin
        got = out_data_i;
        results++;
        if (due_words.size() == 0) begin
          mismatches++;
          $error("result word with none expected: out_byte %h byte_valid %b %s %b class %0d",
                 got.out_byte, got.byte_valid, "frame_end", got.frame_end, got.frame_class);
        end else begin
          want = due_words.pop_front();
          if (got.out_byte !== want.out_byte) begin
            mismatches++;
            $error("out_byte: expected %h, actual %h", want.out_byte, got.out_byte);
          end
          if (got.byte_valid !== want.byte_valid) begin
            mismatches++;
            $error("byte_valid: expected %b, actual %b", want.byte_valid, got.byte_valid);
          end
          if (got.frame_end !== want.frame_end) begin
            mismatches++;
            $error("frame_end: expected %b, actual %b", want.frame_end, got.frame_end);
          end
          if (got.frame_class !== want.frame_class) begin
            mismatches++;
            $error("frame_class: expected %0d, actual %0d", want.frame_class, got.frame_class);
          end
          if (want.frame_end) begin
            frames++;
            classes[want.frame_class] = 1'b1;
          end
        end
      end
    end
    mismatches_o <= mismatches;
    pending_o    <= due_words.size();
    words_in_o   <= words_in;
    results_o    <= results;
    frames_o     <= frames;
    classes_o    <= classes;
  end

endmodule

// File: tb/websocket_frame_deframer_test.sv
// testbench top for the websocket frame deframer: stimulus, flow control and verdict
`timescale 1ns / 100ps

module websocket_frame_deframer_test;

  localparam int unsigned ITEM_TARGET = 2000;
  localparam int unsigned QUIET_TAIL  = 300;
  localparam int unsigned HOLD_AT     = 700;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned CYCLE_LIMIT = 500000;
  localparam int unsigned DRAIN_WAIT  = 8;

  // opcode with no assigned meaning
  localparam logic [3:0] OP_RESERVED = 4'hF;

  logic           clk_i      = 1'b0;
  logic           rst_ni     = 1'b0;
  logic           in_valid   = 1'b0;
  logic           in_stall;
  wsfd_pkg::in_t  in_data    = '0;
  logic           out_valid;
  logic           out_stall  = 1'b0;
  wsfd_pkg::out_t out_data;

  bit idle_on  = 1'b1;
  bit hold_req = 1'b0;

  int unsigned words_sent = 0;
  int unsigned cycles     = 0;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned words_in;
  int unsigned results;
  int unsigned frames;
  logic [8:0]  classes;

  // bytes of the next buffer, buffer_end goes on the last one
  logic [7:0] buf_bytes[$];

  always #6 clk_i = ~clk_i;

  websocket_frame_deframer u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .in_data_i   (in_data),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .out_data_o  (out_data)
  );

  websocket_frame_deframer_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid),
    .in_stall_i   (in_stall),
    .in_data_i    (in_data),
    .out_valid_i  (out_valid),
    .out_stall_i  (out_stall),
    .out_data_i   (out_data),
    .mismatches_o (mismatches),
    .pending_o    (pending),
    .words_in_o   (words_in),
    .results_o    (results),
    .frames_o     (frames),
    .classes_o    (classes)
  );

  // run guard
  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // receiver stalls: random bursts, one long hold-off on request
  initial begin : stall_gen
    bit hold_taken;
    hold_taken = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_req && !hold_taken) begin
        hold_taken = 1'b1;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk_i);
        out_stall <= 1'b0;
      end else if (idle_on && $urandom_range(0, 7) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 11)) @(negedge clk_i);
        out_stall <= 1'b0;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic [7:0] frame_head(input logic fin, input logic [3:0] op);
    return {fin, 3'b000, op};
  endfunction

  // one word on the input channel, entered and left at a falling edge
  task automatic send_byte(input logic [7:0] b, input logic last);
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_data  <= wsfd_pkg::in_t'{data_byte: b, buffer_end: last};
    do @(posedge clk_i); while (in_stall);
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic send_buffer();
    foreach (buf_bytes[i]) send_byte(buf_bytes[i], i == buf_bytes.size() - 1);
  endtask

  // random frame: header, optional extended length and key, payload,
  // then either cut short or followed by a few ignored bytes
  task automatic build_frame();
    logic [3:0]  opc;
    logic        fin;
    logic        masked;
    logic [31:0] key;
    logic [63:0] len64;
    int          pl;
    int          cut;
    bit          force_cut;
    buf_bytes.delete();
    case ($urandom_range(0, 9))
      0:       opc = wsfd_pkg::OP_CONT;
      1, 2:    opc = wsfd_pkg::OP_TEXT;
      3, 4:    opc = wsfd_pkg::OP_BIN;
      5:       opc = wsfd_pkg::OP_PING;
      6:       opc = wsfd_pkg::OP_PONG;
      default: opc = 4'($urandom);
    endcase
    fin       = 1'($urandom);
    masked    = 1'($urandom);
    key       = $urandom;
    force_cut = 1'b0;
    buf_bytes.push_back({fin, 3'($urandom), opc});
    case ($urandom_range(0, 9))
      7, 8: begin
        pl = ($urandom_range(0, 3) == 0) ? $urandom_range(126, 300) : $urandom_range(0, 16);
        buf_bytes.push_back({masked, wsfd_pkg::LEN_EXT16});
        buf_bytes.push_back(pl[15:8]);
        buf_bytes.push_back(pl[7:0]);
      end
      9: begin
        // 64-bit length: small, past LEN_BITS, or too long to send whole
        case ($urandom_range(0, 2))
          0:       len64 = 64'($urandom_range(0, 16));
          1:       len64 = {$urandom, $urandom} | (64'd1 << $urandom_range(32, 63));
          default: len64 = {32'd0, $urandom | 32'h1000_0000};
        endcase
        force_cut = (len64 > 64'd16);
        pl = force_cut ? $urandom_range(0, 8) : int'(len64);
        buf_bytes.push_back({masked, 7'h7F});
        for (int i = 7; i >= 0; i--) buf_bytes.push_back(len64[8*i +: 8]);
      end
      default: begin
        pl = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 125) : $urandom_range(0, 16);
        buf_bytes.push_back({masked, 7'(pl)});
      end
    endcase
    if (masked) for (int i = 0; i < 4; i++) buf_bytes.push_back(key[8*i +: 8]);
    repeat (pl) buf_bytes.push_back(8'($urandom));
    if (force_cut || $urandom_range(0, 6) == 0) begin
      cut = $urandom_range(1, buf_bytes.size());
      while (buf_bytes.size() > cut) void'(buf_bytes.pop_back());
    end else begin
      repeat ($urandom_range(0, 3)) buf_bytes.push_back(8'($urandom));
    end
  endtask

  initial begin : stimulus
    bit held;
    held = 1'b0;

    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed buffers
    // buffer that ends on its first byte
    buf_bytes = '{8'hFF};
    send_buffer();
    // final text frame, one byte
    buf_bytes = '{frame_head(1'b1, wsfd_pkg::OP_TEXT), {1'b0, 7'd1}, 8'h41};
    send_buffer();
    // masked partial binary
    buf_bytes = '{frame_head(1'b0, wsfd_pkg::OP_BIN), {1'b1, 7'd1},
                  8'h11, 8'h22, 8'h44, 8'h88, 8'hFF};
    send_buffer();
    // empty ping with an ignored trailing byte
    buf_bytes = '{frame_head(1'b1, wsfd_pkg::OP_PING), 8'h00, 8'h55};
    send_buffer();
    // empty pong without FIN
    buf_bytes = '{frame_head(1'b0, wsfd_pkg::OP_PONG), 8'h00};
    send_buffer();
    // unknown opcode still passes its payload
    buf_bytes = '{frame_head(1'b1, OP_RESERVED), {1'b0, 7'd2}, 8'h00, 8'hFF};
    send_buffer();
    // 16-bit length, buffer ends on a payload byte
    buf_bytes = '{frame_head(1'b0, wsfd_pkg::OP_CONT), {1'b0, wsfd_pkg::LEN_EXT16},
                  8'h00, 8'h05, 8'hAA};
    send_buffer();

    // random buffers, mostly well-formed frames
    while (words_sent < ITEM_TARGET) begin
      if (!held && words_sent > HOLD_AT) begin
        held     = 1'b1;
        hold_req = 1'b1;
      end
      if (words_sent > ITEM_TARGET - QUIET_TAIL) idle_on = 1'b0;
      else idle_on = ($urandom_range(0, 4) != 0);
      if ($urandom_range(0, 4) == 0) begin
        buf_bytes.delete();
        repeat ($urandom_range(1, 12)) buf_bytes.push_back(8'($urandom));
      end else begin
        build_frame();
      end
      send_buffer();
    end
    in_valid <= 1'b0;

    // drain
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);

    $display("Run: %0d bytes parsed, %0d result words compared, %0d frames or buffers closed",
             words_in, results, frames);
    $display("Frame classes reached, one bit per class code: %b", classes);
    if (mismatches == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// File: files.f
+incdir+rtl
rtl/wsfd_pkg.sv
rtl/wsfd_parser.sv
rtl/websocket_frame_deframer.sv
tb/websocket_frame_deframer_checker.sv
tb/websocket_frame_deframer_test.sv
